// ===== rtl/pra_pkg.sv =====
// Shared constants, types and helper functions for the page run allocator.
// No dependencies; pra_dp, pra_ctrl and page_run_allocator import this package.
`timescale 1ns / 1ps
package pra_pkg;

  localparam int NUM_PAGES   = 64;
  localparam int PAGE_BYTES  = 4096;
  localparam int PAGE_SHIFT  = $clog2(PAGE_BYTES);
  localparam int SMALL_LIMIT = PAGE_BYTES / 2 - 16;

  localparam int SIZE_W   = 20;
  localparam int OFF_W    = 20;
  localparam int STATUS_W = 3;

  localparam int IDX_W   = $clog2(NUM_PAGES);
  localparam int PTR_W   = IDX_W + 1;
  localparam int COUNT_W = $clog2(NUM_PAGES + 1);
  localparam int TAG_W   = COUNT_W;
  // page count before rounding, and after rounding to a power of two
  localparam int CEIL_W  = SIZE_W + 1 - PAGE_SHIFT;
  localparam int NEED_W  = CEIL_W + 1;

  localparam longint MEM_BYTES = longint'(NUM_PAGES) * longint'(PAGE_BYTES);

  localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
  localparam logic [STATUS_W-1:0] ST_NOSPACE = 3'd1;
  localparam logic [STATUS_W-1:0] ST_SMALL   = 3'd2;
  localparam logic [STATUS_W-1:0] ST_RANGE   = 3'd3;
  localparam logic [STATUS_W-1:0] ST_UNALIGN = 3'd4;

  // largest power of two not above the argument (elaboration only)
  function automatic int floor_pow2(input int n);
    int p;
    p = 1;
    for (int i = 0; i < 31; i++) begin
      if ((p << 1) <= n) begin
        p = p << 1;
      end
    end
    return p;
  endfunction

  // a size rounds to a small-path power of two iff it is at most this
  localparam int SMALL_POW = floor_pow2(SMALL_LIMIT);

  // smallest power of two >= n, for n >= 1
  function automatic logic [NEED_W-1:0] ceil_pow2(input logic [CEIL_W-1:0] n);
    logic [CEIL_W-1:0] m;
    logic [NEED_W-1:0] res;
    m   = n - CEIL_W'(1);
    res = NEED_W'(1);
    for (int b = 0; b < CEIL_W; b++) begin
      if (m[b]) begin
        res = NEED_W'(1) << (b + 1);
      end
    end
    return res;
  endfunction

  typedef struct packed {
    logic                accept;
    logic                scan_step;
    logic                tag_begin;
    logic                tag_wr;
    logic                ptr_inc;
    logic                tag_load;
    logic                clr_cur;
    logic                clr_idx;
    logic                res_load;
    logic [STATUS_W-1:0] res_status;
    logic                res_alloc_ok;
  } cmd_t;

  typedef struct packed {
    logic is_free;
    logic small_size;
    logic too_big;
    logic out_range;
    logic unaligned;
    logic run_hit;
    logic scan_last;
    logic tag_last;
    logic chain_stop;
  } stat_t;

endpackage

// ===== rtl/pra_ram.sv =====
// Generic single write port, single read port RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
module pra_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/pra_dp.sv =====
// Datapath: request decode, page-map valid bits, owner tag RAM, scan and
// chain-free pointers, result registers. Uses pra_pkg and pra_ram.
`timescale 1ns / 1ps
module pra_dp
  import pra_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  cmd_t                cmd,
  output stat_t               stat,
  input  logic                in_op,
  input  logic [SIZE_W-1:0]   in_size_bytes,
  input  logic [OFF_W-1:0]    in_byte_offset,
  output logic [STATUS_W-1:0] out_status,
  output logic [IDX_W-1:0]    out_start_page,
  output logic [COUNT_W-1:0]  out_page_count_taken
);

  // decode of the incoming request
  logic [SIZE_W:0]    size_sum;
  logic [CEIL_W-1:0]  ceil_pages;
  logic [NEED_W-1:0]  need_pages;
  logic               dec_small;
  logic               dec_too_big;
  logic               dec_range;
  logic               dec_unalign;
  logic [IDX_W-1:0]   dec_idx;

  logic               is_free_r, small_r, too_big_r, out_range_r, unaligned_r;
  logic               is_free_nxt, small_nxt, too_big_nxt, out_range_nxt, unaligned_nxt;
  logic [COUNT_W-1:0] need_r, need_nxt;
  logic [IDX_W-1:0]   idx_r, idx_nxt;
  logic [PTR_W-1:0]   ptr_r, ptr_nxt;
  logic [COUNT_W-1:0] run_r, run_nxt;
  logic [IDX_W-1:0]   start_r, start_nxt;
  logic [TAG_W-1:0]   tag_r, tag_nxt;
  logic [NUM_PAGES-1:0] valid_r, valid_nxt;
  logic [PTR_W-1:0]   rd_addr_d_r;
  logic               rvalid_r;
  logic [TAG_W-1:0]   rdata;
  logic [TAG_W-1:0]   eff_tag;
  logic               ptr_in_map;
  logic               cur_free;
  logic [COUNT_W-1:0] run_inc;

  logic [STATUS_W-1:0] status_r, status_nxt;
  logic [IDX_W-1:0]    start_out_r, start_out_nxt;
  logic [COUNT_W-1:0]  count_out_r, count_out_nxt;

  always_comb begin
    size_sum    = {1'b0, in_size_bytes} + (SIZE_W + 1)'(PAGE_BYTES - 1);
    ceil_pages  = CEIL_W'(size_sum >> PAGE_SHIFT);
    need_pages  = ceil_pow2(ceil_pages);
    dec_small   = 32'(in_size_bytes) <= 32'(SMALL_POW);
    dec_too_big = 32'(need_pages) > 32'(NUM_PAGES);
    dec_range   = longint'(in_byte_offset) >= MEM_BYTES;
    dec_unalign = in_byte_offset[PAGE_SHIFT-1:0] != '0;
    dec_idx     = IDX_W'(in_byte_offset >> PAGE_SHIFT);
  end

  assign ptr_in_map = ptr_r < PTR_W'(NUM_PAGES);
  assign cur_free   = !(ptr_in_map && valid_r[ptr_r[IDX_W-1:0]]);
  assign run_inc    = run_r + COUNT_W'(1);
  assign eff_tag    = rvalid_r ? rdata : '0;

  always_comb begin
    is_free_nxt   = is_free_r;
    small_nxt     = small_r;
    too_big_nxt   = too_big_r;
    out_range_nxt = out_range_r;
    unaligned_nxt = unaligned_r;
    need_nxt      = need_r;
    idx_nxt       = idx_r;
    ptr_nxt       = ptr_r;
    run_nxt       = run_r;
    start_nxt     = start_r;
    tag_nxt       = tag_r;
    valid_nxt     = valid_r;

    if (cmd.accept) begin
      is_free_nxt   = in_op;
      small_nxt     = dec_small;
      too_big_nxt   = dec_too_big;
      out_range_nxt = dec_range;
      unaligned_nxt = dec_unalign;
      need_nxt      = COUNT_W'(need_pages);
      idx_nxt       = dec_idx;
      ptr_nxt       = in_op ? PTR_W'(dec_idx) : '0;
      run_nxt       = '0;
      start_nxt     = '0;
    end
    if (cmd.scan_step) begin
      ptr_nxt = ptr_r + PTR_W'(1);
      if (cur_free) begin
        run_nxt = run_inc;
      end else begin
        run_nxt   = '0;
        start_nxt = IDX_W'(ptr_r + PTR_W'(1));
      end
    end
    if (cmd.tag_begin) begin
      ptr_nxt = PTR_W'(start_r);
      run_nxt = need_r;
    end
    if (cmd.tag_wr) begin
      valid_nxt[ptr_r[IDX_W-1:0]] = 1'b1;
      ptr_nxt = ptr_r + PTR_W'(1);
      run_nxt = run_r - COUNT_W'(1);
    end
    if (cmd.ptr_inc) begin
      ptr_nxt = ptr_r + PTR_W'(1);
    end
    if (cmd.tag_load) begin
      tag_nxt = eff_tag;
    end
    if (cmd.clr_cur) begin
      valid_nxt[rd_addr_d_r[IDX_W-1:0]] = 1'b0;
    end
    if (cmd.clr_idx) begin
      valid_nxt[idx_r] = 1'b0;
    end
  end

  always_comb begin
    status_nxt    = status_r;
    start_out_nxt = start_out_r;
    count_out_nxt = count_out_r;
    if (cmd.res_load) begin
      status_nxt    = cmd.res_status;
      start_out_nxt = cmd.res_alloc_ok ? start_r : '0;
      count_out_nxt = cmd.res_alloc_ok ? need_r : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    is_free_r   <= is_free_nxt;
    small_r     <= small_nxt;
    too_big_r   <= too_big_nxt;
    out_range_r <= out_range_nxt;
    unaligned_r <= unaligned_nxt;
    need_r      <= need_nxt;
    idx_r       <= idx_nxt;
    ptr_r       <= ptr_nxt;
    run_r       <= run_nxt;
    start_r     <= start_nxt;
    tag_r       <= tag_nxt;
    status_r    <= status_nxt;
    start_out_r <= start_out_nxt;
    count_out_r <= count_out_nxt;
    // address and valid bit travel alongside the RAM read data
    rd_addr_d_r <= ptr_r;
    rvalid_r    <= !cur_free;
  end

  pra_ram #(
    .WIDTH (TAG_W),
    .DEPTH (NUM_PAGES)
  ) u_owner_ram (
    .clk   (clk),
    .we    (cmd.tag_wr),
    .waddr (ptr_r[IDX_W-1:0]),
    .wdata (TAG_W'({1'b0, start_r} + (IDX_W + 1)'(1))),
    .raddr (ptr_r[IDX_W-1:0]),
    .rdata (rdata)
  );

  always_comb begin
    stat.is_free    = is_free_r;
    stat.small_size = small_r;
    stat.too_big    = too_big_r;
    stat.out_range  = out_range_r;
    stat.unaligned  = unaligned_r;
    stat.run_hit    = cur_free && (run_inc == need_r);
    stat.scan_last  = ptr_r == PTR_W'(NUM_PAGES - 1);
    stat.tag_last   = run_r == COUNT_W'(1);
    stat.chain_stop = (rd_addr_d_r == PTR_W'(NUM_PAGES)) || (eff_tag != tag_r);
  end

  assign out_status           = status_r;
  assign out_start_page       = start_out_r;
  assign out_page_count_taken = count_out_r;

endmodule

// ===== rtl/pra_ctrl.sv =====
// Controller: sequences decode, first-fit scan, run tagging and chain free,
// and owns both handshakes. Uses pra_pkg.
`timescale 1ns / 1ps
module pra_ctrl
  import pra_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_stall,
  output logic  out_valid,
  input  logic  out_stall,
  input  stat_t stat,
  output cmd_t  cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECIDE = 3'd1;
  localparam logic [2:0] S_SCAN   = 3'd2;
  localparam logic [2:0] S_TAG    = 3'd3;
  localparam logic [2:0] S_FREAD  = 3'd4;
  localparam logic [2:0] S_FTAG   = 3'd5;
  localparam logic [2:0] S_FLOOP  = 3'd6;
  localparam logic [2:0] S_DONE   = 3'd7;

  logic [2:0]          state_r, state_nxt;
  logic [STATUS_W-1:0] code_r, code_nxt;
  logic                ok_r, ok_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic                slot_free;

  assign in_stall  = state_r != S_IDLE;
  assign slot_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt = state_r;
    code_nxt  = code_r;
    ok_nxt    = ok_r;
    cmd       = '0;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = S_DECIDE;
        end
      end
      S_DECIDE: begin
        ok_nxt = 1'b0;
        if (!stat.is_free) begin
          if (stat.small_size) begin
            code_nxt  = ST_SMALL;
            state_nxt = S_DONE;
          end else if (stat.too_big) begin
            code_nxt  = ST_NOSPACE;
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_SCAN;
          end
        end else begin
          if (stat.out_range) begin
            code_nxt  = ST_RANGE;
            state_nxt = S_DONE;
          end else if (stat.unaligned) begin
            code_nxt  = ST_UNALIGN;
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_FREAD;
          end
        end
      end
      S_SCAN: begin
        if (stat.run_hit) begin
          cmd.tag_begin = 1'b1;
          state_nxt     = S_TAG;
        end else if (stat.scan_last) begin
          code_nxt  = ST_NOSPACE;
          state_nxt = S_DONE;
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      S_TAG: begin
        cmd.tag_wr = 1'b1;
        if (stat.tag_last) begin
          code_nxt  = ST_OK;
          ok_nxt    = 1'b1;
          state_nxt = S_DONE;
        end
      end
      S_FREAD: begin
        cmd.ptr_inc = 1'b1;
        state_nxt   = S_FTAG;
      end
      S_FTAG: begin
        cmd.tag_load = 1'b1;
        cmd.ptr_inc  = 1'b1;
        state_nxt    = S_FLOOP;
      end
      S_FLOOP: begin
        if (stat.chain_stop) begin
          cmd.clr_idx = 1'b1;
          code_nxt    = ST_OK;
          state_nxt   = S_DONE;
        end else begin
          cmd.clr_cur = 1'b1;
          cmd.ptr_inc = 1'b1;
        end
      end
      S_DONE: begin
        if (slot_free) begin
          cmd.res_load     = 1'b1;
          cmd.res_status   = code_r;
          cmd.res_alloc_ok = ok_r;
          state_nxt        = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.res_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      code_r      <= ST_OK;
      ok_r        <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      code_r      <= code_nxt;
      ok_r        <= ok_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// ===== rtl/page_run_allocator.sv =====
// First-fit contiguous page allocator over a 64-entry page map.
// Requests are handled one at a time; the map walk covers one entry per cycle.
// Reset (rst_n low, synchronous): all pages free, no result pending, idle.
// Uses pra_pkg, pra_ctrl, pra_dp (which holds the pra_ram owner table).
`timescale 1ns / 1ps
module page_run_allocator
  import pra_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  // request channel
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                in_op,
  input  logic [SIZE_W-1:0]   in_size_bytes,
  input  logic [OFF_W-1:0]    in_byte_offset,
  // result channel
  output logic                out_valid,
  input  logic                out_stall,
  output logic [STATUS_W-1:0] out_status,
  output logic [IDX_W-1:0]    out_start_page,
  output logic [COUNT_W-1:0]  out_page_count_taken
);

  // Flow of one request:
  //   - accepted in idle; the datapath decodes it (rounded page count,
  //     small-size, range and alignment checks) into flags.
  //   - allocate: walk the valid bits one page per cycle tracking the
  //     current free run; on a long enough run, write the owner tag
  //     (start page + 1) into each page of the run, one page per cycle.
  //   - free: read the owner tag of the addressed page, then stream the
  //     following pages out of the tag RAM, clearing each page whose tag
  //     matches, and stop at the first mismatch or the end of the map.
  //     The addressed page itself is cleared last.
  // A free page has its valid bit low and reads as tag zero, so the tag RAM
  // needs no clearing. The result sits in an output register, so a new
  // request is taken while the previous result still waits.

  cmd_t  cmd;
  stat_t stat;

  pra_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  pra_dp u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .stat                 (stat),
    .in_op                (in_op),
    .in_size_bytes        (in_size_bytes),
    .in_byte_offset       (in_byte_offset),
    .out_status           (out_status),
    .out_start_page       (out_start_page),
    .out_page_count_taken (out_page_count_taken)
  );

endmodule

// ===== tb/sv/pra_tb_pkg.sv =====
// Page ledger for the page run allocator bench: a copy of the page map,
// the queue of grants still awaited, and the per-result comparison.
// Depends on pra_pkg for widths, page geometry and status codes.
`timescale 1ns / 1ps
package pra_tb_pkg;
  import pra_pkg::*;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  typedef struct {
    logic [STATUS_W-1:0] status;
    logic [IDX_W-1:0]    start_page;
    logic [COUNT_W-1:0]  n_pages;
  } grant_t;

  class page_ledger;
    logic [TAG_W-1:0] owner [NUM_PAGES];  // 0 free, else run start + 1
    grant_t           awaited_grants [$];
    int               mismatches;

    function new();
      foreach (owner[i]) owner[i] = '0;
      mismatches = 0;
    endfunction

    function int outstanding();
      return awaited_grants.size();
    endfunction

    // random taken page, optionally only the first page of a run; -1 if none
    function int pick_taken_page(bit run_start_only);
      int cands [$];
      foreach (owner[i]) begin
        if (owner[i] != '0 && (!run_start_only || owner[i] == TAG_W'(i + 1))) begin
          cands.push_back(i);
        end
      end
      if (cands.size() == 0) return -1;
      return cands[$urandom_range(0, cands.size() - 1)];
    endfunction

    // apply one accepted request to the map and queue the grant it produces
    function void note_request(logic op, logic [SIZE_W-1:0] size,
                               logic [OFF_W-1:0] off);
      grant_t          g;
      longint unsigned rounded;
      int              need;
      int              run_len;
      int              run_start;
      int              hit;
      int              idx;
      logic [TAG_W-1:0] tag;
      g.status     = ST_OK;
      g.start_page = '0;
      g.n_pages    = '0;
      if (op == OP_ALLOC) begin
        rounded = 0;
        if (size != '0) begin
          rounded = 1;
          while (rounded < longint'(size)) rounded = rounded << 1;
        end
        if (rounded <= SMALL_LIMIT) begin
          g.status = ST_SMALL;
        end else begin
          need = int'((rounded + PAGE_BYTES - 1) / PAGE_BYTES);
          hit = -1;
          if (need <= NUM_PAGES) begin
            run_len   = 0;
            run_start = 0;
            for (int i = 0; i < NUM_PAGES && hit < 0; i++) begin
              if (owner[i] == '0) begin
                run_len++;
              end else begin
                run_len   = 0;
                run_start = i + 1;
              end
              if (run_len == need) hit = run_start;
            end
          end
          if (hit < 0) begin
            g.status = ST_NOSPACE;
          end else begin
            for (int k = 0; k < need; k++) owner[hit + k] = TAG_W'(hit + 1);
            g.start_page = IDX_W'(hit);
            g.n_pages    = COUNT_W'(need);
          end
        end
      end else begin
        if (longint'(off) >= MEM_BYTES) begin
          g.status = ST_RANGE;
        end else if (off % PAGE_BYTES != 0) begin
          g.status = ST_UNALIGN;
        end else begin
          idx = int'(off / PAGE_BYTES);
          tag = owner[idx];
          for (int j = idx + 1; j < NUM_PAGES && owner[j] == tag; j++) owner[j] = '0;
          owner[idx] = '0;
        end
      end
      awaited_grants.push_back(g);
    endfunction

    function void check_result(logic [STATUS_W-1:0] status, logic [IDX_W-1:0] start_page,
                               logic [COUNT_W-1:0] n_pages);
      grant_t g;
      if (awaited_grants.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("%0t: unexpected result status=%0d start=%0d count=%0d",
                   $time, status, start_page, n_pages);
        end
        return;
      end
      g = awaited_grants.pop_front();
      if (status !== g.status || start_page !== g.start_page || n_pages !== g.n_pages) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("%0t: mismatch expected status=%0d start=%0d count=%0d,",
                   $time, g.status, g.start_page, g.n_pages);
          $display("    got status=%0d start=%0d count=%0d",
                   status, start_page, n_pages);
        end
      end
    endfunction
  endclass

endpackage

// ===== tb/sv/tb_top.sv =====
// Top-level bench for page_run_allocator: directed and random allocate/free
// requests, a burst-driven sender, a patterned stalling receiver and a watchdog.
// Depends on pra_pkg (rtl) and pra_tb_pkg (page ledger).
`timescale 1ns / 1ps
module tb_top;
  import pra_pkg::*;
  import pra_tb_pkg::*;

  localparam int RANDOM_REQUESTS = 650;
  localparam int PAUSE_AT        = 320;   // sender drains the block after this many
  localparam int HOLD_CYCLES     = 300;   // long receiver hold-off
  localparam int IDLE_LIMIT      = 4000;  // cycles with no handshake before giving up
  localparam int TAIL_CYCLES     = 200;   // idle tail after the last drain

  logic                clk;
  logic                rst_n          = 1'b0;
  logic                in_valid       = 1'b0;
  logic                in_stall;
  logic                in_op          = OP_ALLOC;
  logic [SIZE_W-1:0]   in_size_bytes  = '0;
  logic [OFF_W-1:0]    in_byte_offset = '0;
  logic                out_valid;
  logic                out_stall      = 1'b0;
  logic [STATUS_W-1:0] out_status;
  logic [IDX_W-1:0]    out_start_page;
  logic [COUNT_W-1:0]  out_page_count_taken;

  page_ledger ledger = new();

  page_run_allocator u_dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_op                (in_op),
    .in_size_bytes        (in_size_bytes),
    .in_byte_offset       (in_byte_offset),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_status           (out_status),
    .out_start_page       (out_start_page),
    .out_page_count_taken (out_page_count_taken)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Sender side. A request holds valid high until the edge that takes it;
  // back-to-back requests keep valid high, so valid only drops in a gap or a drain.
  // Everything below runs just after a rising edge, so reads see the values
  // from before the edge and all drives are nonblocking.
  // ---------------------------------------------------------------------------
  task automatic send_request(logic op, logic [SIZE_W-1:0] size, logic [OFF_W-1:0] off);
    in_valid       <= 1'b1;
    in_op          <= op;
    in_size_bytes  <= size;
    in_byte_offset <= off;
    do @(posedge clk); while (in_stall);
    // taken at this edge: the ledger sees requests in the block's own order
    ledger.note_request(op, size, off);
  endtask

  task automatic idle_gap(int cycles);
    if (cycles > 0) begin
      in_valid <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  // stop offering and wait until every awaited grant has come back
  task automatic drain_block();
    in_valid <= 1'b0;
    while (ledger.outstanding() != 0) @(posedge clk);
  endtask

  // Mostly well-formed traffic: allocations that fit and frees aimed at live
  // runs, so the map stays busy and first-fit sees fragmented holes. The rest
  // is small sizes, oversized runs, stray offsets and full-range noise.
  task automatic issue_random_request();
    int                pick;
    int                page;
    int                lg;
    logic [SIZE_W-1:0] size;
    logic [OFF_W-1:0]  off;
    pick = $urandom_range(0, 99);
    size = SIZE_W'($urandom);
    off  = OFF_W'($urandom);
    if (pick < 40) begin
      // 1..8 pages usually, now and then up to the whole memory
      lg   = ($urandom_range(0, 19) == 0) ? $urandom_range(4, 6) : $urandom_range(0, 3);
      size = SIZE_W'($urandom_range(SMALL_POW + 1, PAGE_BYTES << lg));
      send_request(OP_ALLOC, size, off);
    end else if (pick < 45) begin
      send_request(OP_ALLOC, SIZE_W'($urandom_range(0, SMALL_POW)), off);
    end else if (pick < 50) begin
      send_request(OP_ALLOC, size, off);
    end else if (pick < 80) begin
      // free a live run from its head, or cut one in the middle
      page = ledger.pick_taken_page($urandom_range(0, 3) != 0);
      if (page < 0) page = $urandom_range(0, NUM_PAGES - 1);
      send_request(OP_FREE, size, OFF_W'(page * PAGE_BYTES));
    end else if (pick < 87) begin
      page = $urandom_range(0, NUM_PAGES - 1);
      send_request(OP_FREE, size, OFF_W'(page * PAGE_BYTES));
    end else if (pick < 93) begin
      page = $urandom_range(0, NUM_PAGES - 1);
      off  = OFF_W'(page * PAGE_BYTES + $urandom_range(1, PAGE_BYTES - 1));
      send_request(OP_FREE, size, off);
    end else begin
      send_request(OP_FREE, size, off);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    int sent;
    int burst;
    int gap_kind;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: small path, whole-memory run, mid-run cuts, range and
    // alignment rejects, frees of free pages, oversized runs.
    send_request(OP_ALLOC, 20'h00000, 20'h00000);  // zero size -> small path
    send_request(OP_ALLOC, 20'h00001, 20'hFFFFF);
    send_request(OP_ALLOC, 20'h00400, 20'h00000);  // largest small size
    send_request(OP_ALLOC, 20'h40000, 20'h00000);  // all 64 pages
    send_request(OP_ALLOC, 20'h01000, 20'h00000);  // map full -> no space
    send_request(OP_FREE,  20'hFFFFF, 20'h20000);  // cut run at page 32
    send_request(OP_ALLOC, 20'h06400, 20'h00000);  // 8 pages into the hole at 32
    send_request(OP_FREE,  20'h00000, 20'h3FFFF);  // last byte: unaligned
    send_request(OP_FREE,  20'h00000, 20'h40000);  // one past the end
    send_request(OP_FREE,  20'h00000, 20'hFFFFF);
    send_request(OP_FREE,  20'h00000, 20'h00001);
    send_request(OP_FREE,  20'h00000, 20'h00000);  // frees pages 0..31
    send_request(OP_FREE,  20'h00000, 20'h05000);  // free of a free page
    send_request(OP_ALLOC, 20'h00401, 20'h00000);  // smallest one-page size
    send_request(OP_ALLOC, 20'h01001, 20'h00000);  // rounds to two pages
    send_request(OP_ALLOC, 20'hFFFFF, 20'h00000);  // 256 pages -> no space
    send_request(OP_ALLOC, 20'h80000, 20'h00000);
    send_request(OP_FREE,  20'h00000, 20'h3F000);  // last page
    send_request(OP_FREE,  20'h00000, 20'h20000);
    send_request(OP_FREE,  20'h00000, 20'h01000);
    send_request(OP_FREE,  20'h00000, 20'h00000);
    send_request(OP_ALLOC, 20'h40000, 20'h00000);  // whole memory again
    send_request(OP_FREE,  20'h00000, 20'h00000);
    drain_block();

    sent = 0;
    while (sent < RANDOM_REQUESTS) begin
      burst = $urandom_range(1, 16);
      for (int k = 0; k < burst && sent < RANDOM_REQUESTS; k++) begin
        issue_random_request();
        sent++;
        if (sent == PAUSE_AT) drain_block();
      end
      gap_kind = $urandom_range(0, 9);
      if (gap_kind < 3) idle_gap(0);
      else if (gap_kind < 8) idle_gap($urandom_range(1, 6));
      else idle_gap($urandom_range(10, 30));
    end

    drain_block();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (ledger.mismatches == 0 && ledger.outstanding() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Receiver: checks each taken result, then picks the next stall value.
  // Stall follows modes that last a random number of cycles; twice in the run
  // it holds off for HOLD_CYCLES so the block backs up into its input.
  // ---------------------------------------------------------------------------
  int results_seen = 0;
  int next_hold_at = 150;
  int hold_left    = 0;
  int stall_mode   = 0;
  int mode_left    = 0;

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        ledger.check_result(out_status, out_start_page, out_page_count_taken);
        results_seen++;
        if (results_seen == next_hold_at) begin
          hold_left    = HOLD_CYCLES;
          next_hold_at = next_hold_at + 300;
        end
      end
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        mode_left  = $urandom_range(64, 256);
      end
      mode_left--;
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        case (stall_mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 99) < 30);
          2: out_stall <= ($urandom_range(0, 99) < 80);
          default: out_stall <= ~out_stall;
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: cycles with no handshake on either side
  // ---------------------------------------------------------------------------
  int quiet_cycles = 0;

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= IDLE_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

endmodule

// ===== sim.f =====
rtl/pra_pkg.sv
rtl/pra_ram.sv
rtl/pra_dp.sv
rtl/pra_ctrl.sv
rtl/page_run_allocator.sv
tb/sv/pra_tb_pkg.sv
tb/sv/tb_top.sv
